[rtl/ffa_pkg.sv]
// Shared types, widths and codes for the first-fit allocator with coalescing.
package ffa_pkg;

  // Size of the managed unit space and of the block table.
  localparam int MEM_UNITS  = 1024;
  localparam int MAX_BLOCKS = 64;

  // Derived widths.
  localparam int ADDR_W = $clog2(MEM_UNITS);
  localparam int LEN_W  = $clog2(MEM_UNITS + 1);
  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int EXT_W  = IDX_W + 2;
  localparam int STAT_W = 2;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_SIZE  = 2'd1,
    STAT_NO_FIT    = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  // One entry of the block table.
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic              free;
  } entry_t;

  // Operation and result of the shared adder/subtractor.
  typedef struct packed {
    logic             sub;
    logic [LEN_W-1:0] a;
    logic [LEN_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [LEN_W-1:0] result;
    logic             msb;
  } alu_rsp_t;

endpackage

[rtl/ffa_in_if.sv]
// Request channel: valid/ready handshake carrying one allocate or free item.
interface ffa_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [ffa_pkg::LEN_W-1:0]  req_size;
  logic [ffa_pkg::ADDR_W-1:0] free_addr;

  modport source (output valid, kind, req_size, free_addr, input ready);
  modport sink   (input valid, kind, req_size, free_addr, output ready);
endinterface

[rtl/ffa_out_if.sv]
// Result channel: valid/ready handshake carrying one status item.
interface ffa_out_if;
  logic                       valid;
  logic                       ready;
  logic [ffa_pkg::STAT_W-1:0] status;
  logic [ffa_pkg::ADDR_W-1:0] granted_addr;

  modport source (output valid, status, granted_addr, input ready);
  modport sink   (input valid, status, granted_addr, output ready);
endinterface

[rtl/ffa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/ffa_alu.sv]
// Shared adder/subtractor used for size compares, splits and merges.
module ffa_alu (
  input  ffa_pkg::alu_req_t req,
  output ffa_pkg::alu_rsp_t rsp
);

  logic [ffa_pkg::LEN_W:0] ext;

  // For a subtraction the top bit is the borrow; for an addition the carry.
  always_comb begin
    if (req.sub) begin
      ext = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      ext = {1'b0, req.a} + {1'b0, req.b};
    end
    rsp.result = ext[ffa_pkg::LEN_W-1:0];
    rsp.msb    = ext[ffa_pkg::LEN_W];
  end

endmodule

[rtl/first_fit_allocator_coalescing_unit.sv]
// First-fit allocator with coalescing. The block table (start, length, free
// mark) lives in a RAM with one write and one registered read port, and a
// small sequencer walks it one entry per clock using a single shared
// adder/subtractor. After reset the block writes the initial free block into
// entry 0 before it takes its first item. An allocate item scans up to the
// first fitting entry; for a split it moves the table entries after that
// entry up by one to make room for the remainder and writes the split. A free
// item scans to the block, folds in free neighbours and moves entries down
// after a merge. The scan position plus the entries moved never exceeds the
// table length, so the worst case is set by the one table read per cycle, and
// the sequencer passes through its idle state before the next item is taken.
// A zero-size allocate is rejected without a table scan. One item is in work
// at a time; a finished result waits in an output register, and the next item
// is taken while it waits.
module first_fit_allocator_coalescing_unit (
  input logic      clk,
  input logic      rst_n,
  ffa_in_if.sink   in_req,
  ffa_out_if.source out_rsp
);

  typedef enum logic [9:0] {
    S_INIT   = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_SCAN   = 10'b00_0000_0100,
    S_SHUP   = 10'b00_0000_1000,
    S_WNEW   = 10'b00_0001_0000,
    S_WCUR   = 10'b00_0010_0000,
    S_FRIGHT = 10'b00_0100_0000,
    S_FUPD   = 10'b00_1000_0000,
    S_SHDN   = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [ffa_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [ffa_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ffa_pkg::IDX_W-1:0]     hit_r, hit_nxt;
  logic                          kind_r, kind_nxt;
  logic [ffa_pkg::LEN_W-1:0]     size_r, size_nxt;
  logic [ffa_pkg::ADDR_W-1:0]    faddr_r, faddr_nxt;
  ffa_pkg::entry_t               cur_r, cur_nxt;
  ffa_pkg::entry_t               prev_r, prev_nxt;
  logic [ffa_pkg::LEN_W-1:0]     acc_r, acc_nxt;
  logic                          lfree_r, lfree_nxt;
  logic                          rfree_r, rfree_nxt;
  ffa_pkg::status_t              res_stat_r, res_stat_nxt;
  logic [ffa_pkg::ADDR_W-1:0]    res_addr_r, res_addr_nxt;
  logic                          out_valid_r, out_valid_nxt;
  ffa_pkg::status_t              out_stat_r, out_stat_nxt;
  logic [ffa_pkg::ADDR_W-1:0]    out_addr_r, out_addr_nxt;

  logic                          ram_we;
  logic [ffa_pkg::IDX_W-1:0]     ram_waddr;
  ffa_pkg::entry_t               ram_wdata;
  ffa_pkg::entry_t               ram_rdata;
  logic [$bits(ffa_pkg::entry_t)-1:0] ram_rword;

  ffa_pkg::alu_req_t             alu_req;
  ffa_pkg::alu_rsp_t             alu_rsp;

  logic [ffa_pkg::CNT_W-1:0]     cnt_m1;
  logic                          is_last;
  logic                          hit_last;
  logic                          full;
  logic [1:0]                    merge_cnt;
  logic [ffa_pkg::EXT_W-1:0]     src_x;
  logic                          has_shift;
  logic                          fits;
  logic                          match;
  logic                          rfree;

  // Block table storage; the read address follows the next index, so the
  // read data always belongs to the current index.
  ffa_ram #(
    .WIDTH ($bits(ffa_pkg::entry_t)),
    .DEPTH (ffa_pkg::MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_nxt),
    .rdata (ram_rword)
  );

  assign ram_rdata = ffa_pkg::entry_t'(ram_rword);

  ffa_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Handshake outputs.
  assign in_req.ready         = (state_r == S_IDLE);
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_stat_r;
  assign out_rsp.granted_addr = out_addr_r;

  // Index and count compares.
  assign cnt_m1    = cnt_r - ffa_pkg::CNT_W'(1);
  assign is_last   = (ffa_pkg::CNT_W'(idx_r) == cnt_m1);
  assign hit_last  = (ffa_pkg::CNT_W'(hit_r) == cnt_m1);
  assign full      = (cnt_r == ffa_pkg::CNT_W'(ffa_pkg::MAX_BLOCKS));
  assign merge_cnt = {1'b0, rfree_r} + {1'b0, lfree_r};
  assign src_x     = ffa_pkg::EXT_W'(hit_r) + ffa_pkg::EXT_W'(1) + ffa_pkg::EXT_W'(rfree_r);
  assign has_shift = (src_x <= ffa_pkg::EXT_W'(cnt_m1));
  assign fits      = ram_rdata.free && !alu_rsp.msb;
  assign match     = (ram_rdata.start == faddr_r) && !ram_rdata.free;
  assign rfree     = !hit_last && ram_rdata.free;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    hit_nxt       = hit_r;
    kind_nxt      = kind_r;
    size_nxt      = size_r;
    faddr_nxt     = faddr_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    acc_nxt       = acc_r;
    lfree_nxt     = lfree_r;
    rfree_nxt     = rfree_r;
    res_stat_nxt  = res_stat_r;
    res_addr_nxt  = res_addr_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_stat_nxt  = out_stat_r;
    out_addr_nxt  = out_addr_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    alu_req       = '0;

    unique case (state_r)
      // Write the single free block that covers the whole space.
      S_INIT: begin
        ram_we         = 1'b1;
        ram_wdata.len  = ffa_pkg::LEN_W'(ffa_pkg::MEM_UNITS);
        ram_wdata.free = 1'b1;
        cnt_nxt        = ffa_pkg::CNT_W'(1);
        idx_nxt        = '0;
        state_nxt      = S_IDLE;
      end

      // Take an item; a zero-size allocate is rejected at once.
      S_IDLE: begin
        idx_nxt = '0;
        if (in_req.valid) begin
          kind_nxt  = in_req.kind;
          size_nxt  = in_req.req_size;
          faddr_nxt = in_req.free_addr;
          if (in_req.kind == ffa_pkg::KIND_ALLOC && in_req.req_size == '0) begin
            res_stat_nxt = ffa_pkg::STAT_BAD_SIZE;
            res_addr_nxt = '0;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      // Walk the table one entry per cycle.
      S_SCAN: begin
        idx_nxt = idx_r + ffa_pkg::IDX_W'(1);
        if (kind_r == ffa_pkg::KIND_ALLOC) begin
          alu_req.sub = 1'b1;
          alu_req.a   = ram_rdata.len;
          alu_req.b   = size_r;
          if (fits) begin
            if (alu_rsp.result == '0) begin
              // Exact fit: only the free mark changes.
              ram_we         = 1'b1;
              ram_waddr      = idx_r;
              ram_wdata      = ram_rdata;
              ram_wdata.free = 1'b0;
              res_stat_nxt   = ffa_pkg::STAT_OK;
              res_addr_nxt   = ram_rdata.start;
              idx_nxt        = '0;
              state_nxt      = S_DONE;
            end else if (full) begin
              // A split needs a new entry and the table has no room.
              res_stat_nxt = ffa_pkg::STAT_NO_FIT;
              res_addr_nxt = '0;
              idx_nxt      = '0;
              state_nxt    = S_DONE;
            end else begin
              hit_nxt = idx_r;
              cur_nxt = ram_rdata;
              acc_nxt = alu_rsp.result;
              if (is_last) begin
                state_nxt = S_WNEW;
              end else begin
                idx_nxt   = ffa_pkg::IDX_W'(cnt_m1);
                state_nxt = S_SHUP;
              end
            end
          end else if (is_last) begin
            res_stat_nxt = ffa_pkg::STAT_NO_FIT;
            res_addr_nxt = '0;
            idx_nxt      = '0;
            state_nxt    = S_DONE;
          end
        end else begin
          if (match) begin
            hit_nxt   = idx_r;
            cur_nxt   = ram_rdata;
            lfree_nxt = (idx_r != '0) && prev_r.free;
            state_nxt = S_FRIGHT;
          end else if (is_last) begin
            res_stat_nxt = ffa_pkg::STAT_NOT_FOUND;
            res_addr_nxt = '0;
            idx_nxt      = '0;
            state_nxt    = S_DONE;
          end else begin
            prev_nxt = ram_rdata;
          end
        end
      end

      // Move entries up by one, from the end down to just after the hit.
      S_SHUP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r + ffa_pkg::IDX_W'(1);
        ram_wdata = ram_rdata;
        if (idx_r == hit_r + ffa_pkg::IDX_W'(1)) begin
          state_nxt = S_WNEW;
        end else begin
          idx_nxt = idx_r - ffa_pkg::IDX_W'(1);
        end
      end

      // Write the free remainder after the allocated block.
      S_WNEW: begin
        alu_req.a      = ffa_pkg::LEN_W'(cur_r.start);
        alu_req.b      = size_r;
        ram_we         = 1'b1;
        ram_waddr      = hit_r + ffa_pkg::IDX_W'(1);
        ram_wdata.start = alu_rsp.result[ffa_pkg::ADDR_W-1:0];
        ram_wdata.len  = acc_r;
        ram_wdata.free = 1'b1;
        state_nxt      = S_WCUR;
      end

      // Shrink the hit entry to the request and mark it used.
      S_WCUR: begin
        ram_we          = 1'b1;
        ram_waddr       = hit_r;
        ram_wdata.start = cur_r.start;
        ram_wdata.len   = size_r;
        ram_wdata.free  = 1'b0;
        cnt_nxt         = cnt_r + ffa_pkg::CNT_W'(1);
        res_stat_nxt    = ffa_pkg::STAT_OK;
        res_addr_nxt    = cur_r.start;
        idx_nxt         = '0;
        state_nxt       = S_DONE;
      end

      // Right neighbour is on the read port: fold it in if it is free.
      S_FRIGHT: begin
        alu_req.a = cur_r.len;
        alu_req.b = rfree ? ram_rdata.len : '0;
        acc_nxt   = alu_rsp.result;
        rfree_nxt = rfree;
        state_nxt = S_FUPD;
      end

      // Fold in a free left neighbour and write the merged entry.
      S_FUPD: begin
        alu_req.a    = acc_r;
        alu_req.b    = lfree_r ? prev_r.len : '0;
        ram_we       = 1'b1;
        res_stat_nxt = ffa_pkg::STAT_OK;
        res_addr_nxt = '0;
        if (lfree_r) begin
          ram_waddr       = hit_r - ffa_pkg::IDX_W'(1);
          ram_wdata.start = prev_r.start;
          ram_wdata.len   = alu_rsp.result;
        end else begin
          ram_waddr       = hit_r;
          ram_wdata.start = cur_r.start;
          ram_wdata.len   = acc_r;
        end
        ram_wdata.free = 1'b1;
        if (merge_cnt == 2'd0) begin
          idx_nxt   = '0;
          state_nxt = S_DONE;
        end else if (has_shift) begin
          idx_nxt   = ffa_pkg::IDX_W'(src_x);
          state_nxt = S_SHDN;
        end else begin
          cnt_nxt   = cnt_r - ffa_pkg::CNT_W'(merge_cnt);
          idx_nxt   = '0;
          state_nxt = S_DONE;
        end
      end

      // Close the gap left by merged entries, one entry per cycle.
      S_SHDN: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r - ffa_pkg::IDX_W'(merge_cnt);
        ram_wdata = ram_rdata;
        if (is_last) begin
          cnt_nxt   = cnt_r - ffa_pkg::CNT_W'(merge_cnt);
          idx_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + ffa_pkg::IDX_W'(1);
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        idx_nxt = '0;
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_addr_nxt  = res_addr_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      idx_r       <= '0;
      cnt_r       <= ffa_pkg::CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    hit_r      <= hit_nxt;
    kind_r     <= kind_nxt;
    size_r     <= size_nxt;
    faddr_r    <= faddr_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    acc_r      <= acc_nxt;
    lfree_r    <= lfree_nxt;
    rfree_r    <= rfree_nxt;
    res_stat_r <= res_stat_nxt;
    res_addr_r <= res_addr_nxt;
    out_stat_r <= out_stat_nxt;
    out_addr_r <= out_addr_nxt;
  end

`ifndef SYNTHESIS
  // The table never empties and never exceeds its capacity.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r <= ffa_pkg::CNT_W'(ffa_pkg::MAX_BLOCKS)))
    else $error("block count out of range");

  // Table writes stay within the occupied entries plus one.
  a_wr_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (ffa_pkg::CNT_W'(ram_waddr) <= cnt_r))
    else $error("table write beyond the occupied entries");

  // A split is only completed when the table had room for it.
  a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WCUR) |-> (cnt_r < ffa_pkg::CNT_W'(ffa_pkg::MAX_BLOCKS)))
    else $error("split completed on a full table");

  // A new result only appears after the sequencer has finished an item.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done state");
`endif

endmodule
